FILE: design/nrbr_pkg.sv
// ============================================================================
// nrbr_pkg - shared types and constants of the NAL RBSP bit reader
// Command codes, the decoded command record passed from the front end to the
// back end, result status codes, sizes and small mask helpers.
// ============================================================================
package nrbr_pkg;

	localparam int BUFFER_DEPTH = 1024;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = 17;
	localparam int REM_W        = 14;
	localparam int DROP_W       = 11;
	localparam int VAL_W        = 33;
	localparam logic [7:0]  EPB_BYTE = 8'h03;
	localparam logic [15:0] LAST_TWO_RESET = 16'hffff;
	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_PUSH  = 3'd1,
		CMD_READ  = 3'd2,
		CMD_SKIP  = 3'd3,
		CMD_UE    = 3'd4,
		CMD_SE    = 3'd5,
		CMD_MORE  = 3'd6,
		CMD_BAD   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_DATA  = 2'd1,
		STS_TOO_LONG = 2'd2,
		STS_BAD      = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic             bad;
		logic [7:0]       data;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// Low n bits set, n from 0 to 8.
	function automatic logic [7:0] mask8(input logic [3:0] n);
		logic [8:0] t;
		t = (9'd1 << n) - 9'd1;
		return t[7:0];
	endfunction

	// Low n bits set, n from 0 to 31.
	function automatic logic [31:0] mask32(input logic [5:0] n);
		logic [32:0] t;
		t = (33'd1 << n) - 33'd1;
		return t[31:0];
	endfunction

endpackage

FILE: design/nrbr_front.sv
// ============================================================================
// nrbr_front - command intake and classification
// Decodes each accepted command, flags bad counts and holds it in a two-entry
// queue until the back end takes it.
// ============================================================================
module nrbr_front import nrbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       command,
	input  logic [7:0]       data_byte,
	input  logic [CNT_W-1:0] count,
	output logic             q_valid,
	output cmd_t             q_cmd,
	input  logic             q_pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.op    = op_t'(command);
		cls.data  = data_byte;
		cls.count = count;
		unique case (op_t'(command))
			CMD_BEGIN: cls.bad = (count == '0) || (count > CNT_W'(BUFFER_DEPTH));
			CMD_READ:  cls.bad = (count > CNT_W'(31));
			CMD_BAD:   cls.bad = 1'b1;
			default:   cls.bad = 1'b0;
		endcase
	end

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue fill out of range");
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (fill_q == $past(fill_q) + 2'd1))
		else $error("queue fill did not advance");

endmodule

FILE: design/nrbr_back.sv
// ============================================================================
// nrbr_back - byte store and bit reading sequencer
// Executes queued commands: stores pushed bytes, loads bytes with emulation
// prevention removal, reads and skips bits, decodes Exp-Golomb codes.
// ============================================================================
module nrbr_back import nrbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              done,
	output logic [1:0]        status,
	output logic [VAL_W-1:0]  value,
	output logic              more_data,
	output logic [REM_W-1:0]  bits_remaining,
	output logic [DROP_W-1:0] dropped_byte_count
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RB, ST_PFX, ST_SIGN, ST_MORE, ST_LDREQ, ST_LDDATA, ST_RESP
	} state_t;

	logic [7:0]        mem [BUFFER_DEPTH];
	logic [7:0]        rdata_q;
	logic              mem_we;
	logic              mem_re;

	state_t            state_q, state_d, ret_q, ret_d;
	op_t               op_q, op_d;
	logic              peek_ok_q, peek_ok_d;
	logic [IDX_W-1:0]  wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d, unread_q, unread_d;
	logic [IDX_W-1:0]  nz_q, nz_d;
	logic [7:0]        cur_q, cur_d;
	logic [3:0]        bits_q, bits_d;
	logic [15:0]       last2_q, last2_d;
	logic [DROP_W-1:0] drop_q, drop_d;
	logic [CNT_W-1:0]  left_q, left_d;
	logic [31:0]       acc_q, acc_d;
	logic [5:0]        zeros_q, zeros_d;
	status_t           status_q, status_d;
	logic [VAL_W-1:0]  value_q, value_d;
	logic              more_q, more_d;

	logic [3:0]        left4;
	logic [31:0]       fin_acc;
	logic [7:0]        ld_byte;
	logic [VAL_W-1:0]  half;
	logic              pfx_bit;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q[ADDR_W-1:0]] <= q_cmd.data;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_comb begin
		left4   = left_q[3:0];
		fin_acc = (acc_q << left4) | 32'((cur_q >> (bits_q - left4)) & mask8(left4));
		ld_byte = peek_ok_q ? rdata_q : 8'd0;
		half    = {1'b0, value_q[VAL_W-1:1]};
		pfx_bit = cur_q[3'(bits_q - 4'd1)];
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		op_d      = op_q;
		peek_ok_d = peek_ok_q;
		wr_idx_d  = wr_idx_q;
		rd_idx_d  = rd_idx_q;
		unread_d  = unread_q;
		nz_d      = nz_q;
		cur_d     = cur_q;
		bits_d    = bits_q;
		last2_d   = last2_q;
		drop_d    = drop_q;
		left_d    = left_q;
		acc_d     = acc_q;
		zeros_d   = zeros_q;
		status_d  = status_q;
		value_d   = value_q;
		more_d    = more_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					op_d     = q_cmd.op;
					status_d = STS_OK;
					value_d  = '0;
					more_d   = 1'b0;
					unique case (q_cmd.op)
						CMD_BEGIN: begin
							state_d = ST_RESP;
							if (q_cmd.bad) begin
								status_d = STS_BAD;
							end else begin
								wr_idx_d = '0;
								rd_idx_d = '0;
								unread_d = IDX_W'(q_cmd.count);
								cur_d    = '0;
								bits_d   = '0;
								last2_d  = LAST_TWO_RESET;
								drop_d   = '0;
								nz_d     = '0;
							end
						end
						CMD_PUSH: begin
							state_d = ST_RESP;
							if (wr_idx_q >= IDX_W'(BUFFER_DEPTH) ||
								{1'b0, wr_idx_q} >= {1'b0, rd_idx_q} + {1'b0, unread_q}) begin
								status_d = STS_BAD;
							end else begin
								mem_we = 1'b1;
								if (wr_idx_q >= rd_idx_q && q_cmd.data != 8'd0) begin
									nz_d = nz_q + 1'b1;
								end
								wr_idx_d = wr_idx_q + 1'b1;
							end
						end
						CMD_READ, CMD_SKIP: begin
							if (q_cmd.bad) begin
								status_d = STS_BAD;
								state_d  = ST_RESP;
							end else begin
								left_d  = q_cmd.count;
								acc_d   = '0;
								state_d = ST_RB;
							end
						end
						CMD_UE, CMD_SE: begin
							zeros_d = '0;
							state_d = ST_PFX;
						end
						CMD_MORE: begin
							if (bits_q == 4'd0) begin
								ret_d   = ST_MORE;
								state_d = ST_LDREQ;
							end else begin
								state_d = ST_MORE;
							end
						end
						default: begin
							status_d = STS_BAD;
							state_d  = ST_RESP;
						end
					endcase
				end
			end
			ST_RB: begin
				if (CNT_W'(bits_q) >= left_q) begin
					bits_d = bits_q - left4;
					if (op_q == CMD_READ) begin
						value_d = {1'b0, fin_acc};
						state_d = ST_RESP;
					end else if (op_q == CMD_SKIP) begin
						state_d = ST_RESP;
					end else begin
						value_d = {1'b0, mask32(zeros_q)} + {1'b0, fin_acc};
						state_d = ST_SIGN;
					end
				end else begin
					acc_d   = (acc_q << bits_q) | 32'(cur_q & mask8(bits_q));
					left_d  = left_q - CNT_W'(bits_q);
					ret_d   = ST_RB;
					state_d = ST_LDREQ;
				end
			end
			ST_PFX: begin
				if (bits_q != 4'd0) begin
					bits_d = bits_q - 4'd1;
					if (pfx_bit) begin
						if (zeros_q > 6'd31) begin
							status_d = STS_TOO_LONG;
							value_d  = '0;
							state_d  = ST_RESP;
						end else if (zeros_q == 6'd0) begin
							value_d = '0;
							state_d = ST_SIGN;
						end else begin
							left_d  = CNT_W'(zeros_q);
							acc_d   = '0;
							state_d = ST_RB;
						end
					end else if (zeros_q != 6'd32) begin
						zeros_d = zeros_q + 6'd1;
					end
				end else begin
					ret_d   = ST_PFX;
					state_d = ST_LDREQ;
				end
			end
			ST_SIGN: begin
				if (op_q == CMD_SE) begin
					value_d = value_q[0] ? half + VAL_W'(1) : VAL_W'(0) - half;
				end
				state_d = ST_RESP;
			end
			ST_MORE: begin
				state_d = ST_RESP;
				if ((cur_q & mask8(bits_q - 4'd1)) != 8'd0 || nz_q != '0) begin
					more_d = 1'b1;
				end else begin
					more_d   = 1'b0;
					unread_d = '0;
				end
			end
			ST_LDREQ: begin
				if (unread_q == '0) begin
					state_d = ST_RESP;
					if (op_q == CMD_MORE) begin
						more_d = 1'b0;
					end else begin
						status_d = STS_NO_DATA;
						value_d  = '0;
					end
				end else begin
					mem_re    = 1'b1;
					peek_ok_d = (rd_idx_q < wr_idx_q);
					state_d   = ST_LDDATA;
				end
			end
			ST_LDDATA: begin
				rd_idx_d = rd_idx_q + 1'b1;
				unread_d = unread_q - 1'b1;
				if (ld_byte != 8'd0 && nz_q != '0) begin
					nz_d = nz_q - 1'b1;
				end
				if (ld_byte == EPB_BYTE && last2_q == 16'd0) begin
					if (drop_q != DROP_MAX) begin
						drop_d = drop_q + 1'b1;
					end
					last2_d = LAST_TWO_RESET;
					state_d = ST_LDREQ;
				end else begin
					cur_d   = ld_byte;
					bits_d  = 4'd8;
					last2_d = {last2_q[7:0], ld_byte};
					state_d = ret_q;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			op_q     <= CMD_BAD;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			unread_q <= '0;
			nz_q     <= '0;
			cur_q    <= '0;
			bits_q   <= '0;
			last2_q  <= LAST_TWO_RESET;
			drop_q   <= '0;
			status_q <= STS_OK;
			more_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			op_q     <= op_d;
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			unread_q <= unread_d;
			nz_q     <= nz_d;
			cur_q    <= cur_d;
			bits_q   <= bits_d;
			last2_q  <= last2_d;
			drop_q   <= drop_d;
			status_q <= status_d;
			more_q   <= more_d;
		end
	end

	always_ff @(posedge clk) begin
		peek_ok_q <= peek_ok_d;
		left_q    <= left_d;
		acc_q     <= acc_d;
		zeros_q   <= zeros_d;
		value_q   <= value_d;
	end

	assign done               = (state_q == ST_RESP);
	assign status             = status_q;
	assign value              = value_q;
	assign more_data          = more_q;
	assign bits_remaining     = REM_W'({unread_q, 3'b000}) + REM_W'(bits_q);
	assign dropped_byte_count = drop_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= 4'd8) else $error("bit count above a byte");
	a_unread_range: assert property (@(posedge clk) disable iff (!arst_n)
		unread_q <= IDX_W'(BUFFER_DEPTH)) else $error("unread bytes above depth");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE)) else $error("command taken while working");

endmodule

FILE: design/nal_rbsp_bit_reader_top.sv
// ============================================================================
// nal_rbsp_bit_reader_top - H.264/H.265 NAL unit RBSP bit reader
// Reads bits, skips bits and decodes Exp-Golomb codes from a NAL unit held in
// an internal byte store, removing emulation prevention bytes on the fly.
// ============================================================================
//
// Channel   Direction  Handshake           Payload
// command   in         start high, busy low command, data_byte, count
// result    out        done, one cycle      status, value, more_data,
//                                           bits_remaining, dropped_byte_count
//
// A command transfer takes place at a rising edge with start high and busy low.
// With the back end idle, begin, push and rejected commands pass through the
// queue and then the response state before their result shows. A read or
// skip steps through the bit sequencer, loading each byte it needs through a
// request and a data state; an emulation prevention byte takes one more pair.
// An Exp-Golomb code steps through its prefix bits, loading bytes as needed,
// then reads the suffix and takes one sign step. These steps are set by the
// single byte store read port and the bit sequencer in the back end.
// Reset is asynchronous and active low; it empties the queue and clears the
// reader state, while the byte store contents stay undefined until pushed.
// Results cannot be stalled: each appears for exactly one cycle with done high.
// The two-entry queue lets commands be taken while the back end is working.
// ============================================================================
module nal_rbsp_bit_reader_top import nrbr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               command,
	input  logic [7:0]               data_byte,
	input  logic [CNT_W-1:0]         count,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [VAL_W-1:0]  value,
	output logic                     more_data,
	output logic [REM_W-1:0]         bits_remaining,
	output logic [DROP_W-1:0]        dropped_byte_count
);

	// Decoded commands waiting between the front and back ends.
	logic             q_valid;
	logic             q_pop;
	cmd_t             q_cmd;
	logic [VAL_W-1:0] value_raw;

	// The front end classifies each command transfer and queues it.
	nrbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.data_byte (data_byte),
		.count     (count),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	// The back end owns the byte store and all reader state.
	nrbr_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_valid            (q_valid),
		.q_cmd              (q_cmd),
		.q_pop              (q_pop),
		.done               (done),
		.status             (status),
		.value              (value_raw),
		.more_data          (more_data),
		.bits_remaining     (bits_remaining),
		.dropped_byte_count (dropped_byte_count)
	);

	// The signed Exp-Golomb result is kept in two's complement throughout.
	assign value = $signed(value_raw);

endmodule

FILE: bench/nal_rbsp_bit_reader_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// nal_rbsp_bit_reader_top_tb - self-checking bench for the NAL RBSP bit reader
// A clocked driver sends commands from a queue of pending items that the
// stimulus process fills. A bit-exact predictor computes the result of every
// accepted command, and a clocked monitor checks each done pulse against it.
// ============================================================================
module nal_rbsp_bit_reader_top_tb;
	import nrbr_pkg::*;

	typedef struct {
		logic [2:0]       cmd;
		logic [7:0]       data;
		logic [CNT_W-1:0] cnt;
		int               gap_pct;  // chance per cycle that the sender holds off
		bit               drain;    // pause until every expected result is in
	} pending_item_t;

	typedef struct {
		logic [1:0]        status;
		logic [VAL_W-1:0]  value;
		logic              more;
		logic [REM_W-1:0]  rem;
		logic [DROP_W-1:0] dropped;
	} reader_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [2:0]              command = CMD_BEGIN;
	logic [7:0]              data_byte = 8'd0;
	logic [CNT_W-1:0]        count = '0;
	logic                    busy;
	logic                    done;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] value;
	logic                    more_data;
	logic [REM_W-1:0]        bits_remaining;
	logic [DROP_W-1:0]       dropped_byte_count;

	pending_item_t  pending_cmds[$];
	reader_result_t expected_results[$];
	int             n_sent = 0;
	int             n_results = 0;
	int             n_errors = 0;
	int             n_units = 0;
	int             cur_gap = 0;

	nal_rbsp_bit_reader_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .data_byte(data_byte), .count(count),
		.done(done), .status(status), .value(value), .more_data(more_data),
		.bits_remaining(bits_remaining), .dropped_byte_count(dropped_byte_count)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: a shadow copy of the reader, kept in wider integer types.
	// ------------------------------------------------------------------------
	logic [7:0]  nal_mem [BUFFER_DEPTH];
	int unsigned wr_idx = 0, rd_idx = 0, unread = 0;
	logic [7:0]  cur_byte = 8'd0;
	int unsigned cur_bits = 0;
	logic [15:0] last_two = LAST_TWO_RESET;
	int unsigned drop_cnt = 0, nonzero_left = 0;

	// Positions that were never pushed read as zero, so the store is never
	// read where it holds nothing.
	function automatic logic [7:0] peek_nal();
		if (rd_idx < wr_idx && rd_idx < BUFFER_DEPTH)
			return nal_mem[rd_idx];
		return 8'd0;
	endfunction

	function automatic logic [7:0] take_nal();
		logic [7:0] b;
		b = peek_nal();
		if (b != 0 && nonzero_left > 0)
			nonzero_left--;
		rd_idx++;
		unread--;
		return b;
	endfunction

	// Loads the next byte, dropping an emulation prevention byte on the way.
	function automatic bit load_nal();
		logic [7:0] b;
		if (unread == 0)
			return 1'b0;
		if (peek_nal() == EPB_BYTE && last_two == 16'h0000) begin
			void'(take_nal());
			if (drop_cnt < 2047)
				drop_cnt++;
			last_two = LAST_TWO_RESET;
			if (unread == 0)
				return 1'b0;
		end
		b = take_nal();
		cur_byte = b;
		cur_bits = 8;
		last_two = {last_two[7:0], b};
		return 1'b1;
	endfunction

	function automatic bit fetch_bits(input int unsigned n, output longint unsigned v);
		int unsigned left;
		longint unsigned acc;
		left = n;
		acc = 0;
		v = 0;
		while (cur_bits < left) begin
			acc |= longint'(cur_byte) << (left - cur_bits);
			left -= cur_bits;
			if (!load_nal())
				return 1'b0;
		end
		acc |= longint'(cur_byte >> (cur_bits - left));
		acc &= (64'd1 << n) - 64'd1;
		cur_bits -= left;
		v = acc;
		return 1'b1;
	endfunction

	function automatic bit skip_nal(input int unsigned n);
		int unsigned left;
		left = n;
		while (cur_bits < left) begin
			left -= cur_bits;
			if (!load_nal())
				return 1'b0;
		end
		cur_bits -= left;
		return 1'b1;
	endfunction

	function automatic logic [1:0] decode_ue(output longint unsigned v);
		int unsigned zeros;
		longint unsigned b, rest;
		zeros = 0;
		rest = 0;
		v = 0;
		forever begin
			if (!fetch_bits(1, b))
				return STS_NO_DATA;
			if (b != 0)
				break;
			if (zeros < 32'hffff_ffff)
				zeros++;
		end
		if (zeros > 31)
			return STS_TOO_LONG;
		if (zeros > 0 && !fetch_bits(zeros, rest))
			return STS_NO_DATA;
		v = ((64'd1 << zeros) - 64'd1) + rest;
		return STS_OK;
	endfunction

	// Applies one accepted command to the shadow reader and returns its result.
	function automatic reader_result_t apply_command(input logic [2:0] cmd,
			input logic [7:0] data, input logic [CNT_W-1:0] cnt);
		reader_result_t r;
		longint unsigned v, u, rem;
		longint s;
		r.status = STS_OK;
		r.more = 1'b0;
		v = 0;
		case (cmd)
			CMD_BEGIN: begin
				if (cnt < 1 || cnt > BUFFER_DEPTH) begin
					r.status = STS_BAD;
				end else begin
					wr_idx = 0; rd_idx = 0; unread = cnt;
					cur_byte = 0; cur_bits = 0; last_two = LAST_TWO_RESET;
					drop_cnt = 0; nonzero_left = 0;
				end
			end
			CMD_PUSH: begin
				if (wr_idx >= BUFFER_DEPTH || wr_idx >= rd_idx + unread) begin
					r.status = STS_BAD;
				end else begin
					nal_mem[wr_idx] = data;
					if (wr_idx >= rd_idx && data != 0)
						nonzero_left++;
					wr_idx++;
				end
			end
			CMD_READ: begin
				if (cnt > 31)
					r.status = STS_BAD;
				else if (!fetch_bits(cnt, v)) begin
					r.status = STS_NO_DATA;
					v = 0;
				end
			end
			CMD_SKIP: begin
				if (!skip_nal(cnt))
					r.status = STS_NO_DATA;
			end
			CMD_UE: r.status = decode_ue(v);
			CMD_SE: begin
				r.status = decode_ue(u);
				if (r.status == STS_OK) begin
					if (u[0] == 1'b0)
						s = -longint'(u >> 1);
					else
						s = longint'(u >> 1) + 1;
					v = s;
				end
			end
			CMD_MORE: begin
				// The query answers true as soon as a set bit lies past the
				// current position; otherwise the rest of the unit is dropped.
				if (cur_bits == 0 && !load_nal())
					r.more = 1'b0;
				else if ((cur_byte & mask8(4'(cur_bits - 1))) != 0)
					r.more = 1'b1;
				else if (nonzero_left > 0)
					r.more = 1'b1;
				else
					unread = 0;
			end
			default: r.status = STS_BAD;
		endcase
		rem = longint'(cur_bits) + longint'(unread) * 8;
		if (rem > 16383)
			rem = 16383;
		r.value = v[VAL_W-1:0];
		r.rem = rem[REM_W-1:0];
		r.dropped = drop_cnt[DROP_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver. A transfer happens at an edge where start is high and busy is
	// low; the values sampled here are those from before the edge.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_command(command, data_byte, count));
				n_sent <= n_sent + 1;
			end
			if (start && busy) begin
				// Hold the command until the reader takes it.
			end else if (pending_cmds.size() == 0) begin
				start <= 1'b0;
			end else if (pending_cmds[0].drain) begin
				start <= 1'b0;
				// Both counters update after this edge, so a transfer made at
				// this edge also keeps the drain item waiting.
				if (!(start && !busy) && n_sent == n_results)
					void'(pending_cmds.pop_front());
			end else if ($urandom_range(99) < pending_cmds[0].gap_pct) begin
				start <= 1'b0;
			end else begin
				start     <= 1'b1;
				command   <= pending_cmds[0].cmd;
				data_byte <= pending_cmds[0].data;
				count     <= pending_cmds[0].cnt;
				void'(pending_cmds.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Each done pulse is matched against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		reader_result_t e;
		if (arst_n && done) begin
			n_results <= n_results + 1;
			if (expected_results.size() == 0) begin
				$error("result with no command outstanding");
				n_errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					n_errors++;
				end
				if (value !== e.value) begin
					$error("value: expected %0h, got %0h", e.value, value);
					n_errors++;
				end
				if (more_data !== e.more) begin
					$error("more_data: expected %0d, got %0d", e.more, more_data);
					n_errors++;
				end
				if (bits_remaining !== e.rem) begin
					$error("bits_remaining: expected %0d, got %0d", e.rem, bits_remaining);
					n_errors++;
				end
				if (dropped_byte_count !== e.dropped) begin
					$error("dropped_byte_count: expected %0d, got %0d",
						e.dropped, dropped_byte_count);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_cmd(input logic [2:0] cmd, input logic [7:0] data,
			input logic [CNT_W-1:0] cnt);
		pending_item_t it;
		it.cmd = cmd; it.data = data; it.cnt = cnt;
		it.gap_pct = cur_gap; it.drain = 1'b0;
		pending_cmds.push_back(it);
	endtask

	task automatic queue_drain();
		pending_item_t it;
		it.cmd = CMD_BEGIN; it.data = 0; it.cnt = 0;
		it.gap_pct = 0; it.drain = 1'b1;
		pending_cmds.push_back(it);
	endtask

	// Bytes are biased towards zeros and 0x03 so that emulation prevention
	// patterns and long Exp-Golomb prefixes turn up often.
	function automatic logic [7:0] nal_byte();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 30) return 8'h00;
		if (p < 42) return EPB_BYTE;
		if (p < 50) return 8'h01;
		return 8'($urandom);
	endfunction

	task automatic queue_parse_cmd();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 30)
			queue_cmd(CMD_READ, 8'($urandom), CNT_W'($urandom_range(31)));
		else if (p < 33)
			queue_cmd(CMD_READ, 8'($urandom), CNT_W'($urandom));
		else if (p < 43)
			queue_cmd(CMD_SKIP, 8'($urandom), CNT_W'($urandom_range(24)));
		else if (p < 45)
			queue_cmd(CMD_SKIP, 8'($urandom), CNT_W'($urandom));
		else if (p < 68)
			queue_cmd(CMD_UE, 8'($urandom), CNT_W'($urandom));
		else if (p < 88)
			queue_cmd(CMD_SE, 8'($urandom), CNT_W'($urandom));
		else if (p < 96)
			queue_cmd(CMD_MORE, 8'($urandom), CNT_W'($urandom));
		else if (p < 98)
			queue_cmd(CMD_PUSH, nal_byte(), CNT_W'($urandom));
		else
			queue_cmd(CMD_BAD, 8'($urandom), CNT_W'($urandom));
	endtask

	// One NAL unit: begin, the bytes, then parsing commands. Now and then the
	// unit is left short or a bad length is given to break the sequence.
	task automatic queue_unit(input int unsigned nbytes);
		int unsigned npush, nparse;
		n_units++;
		if ($urandom_range(19) == 0)
			queue_cmd(CMD_BEGIN, 8'($urandom),
				$urandom_range(1) ? CNT_W'(0) : CNT_W'($urandom_range(131071, 1025)));
		queue_cmd(CMD_BEGIN, 8'($urandom), CNT_W'(nbytes));
		npush = ($urandom_range(9) == 0) ? $urandom_range(nbytes) : nbytes;
		repeat (npush)
			queue_cmd(CMD_PUSH, nal_byte(), CNT_W'($urandom));
		nparse = $urandom_range(2 + nbytes, 1);
		repeat (nparse)
			queue_parse_cmd();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed cases, then random phases.
	// ------------------------------------------------------------------------
	initial begin
		int phase_gap[4] = '{0, 86, 0, 16};
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Bad lengths, a push with no unit open and the unknown command.
		queue_cmd(CMD_BEGIN, 8'h00, CNT_W'(0));
		queue_cmd(CMD_BEGIN, 8'hff, CNT_W'(BUFFER_DEPTH + 1));
		queue_cmd(CMD_PUSH, 8'hff, '1);
		queue_cmd(CMD_BAD, 8'hff, '1);
		// A read before any byte is pushed sees zeros.
		queue_cmd(CMD_BEGIN, 8'h00, CNT_W'(8));
		queue_cmd(CMD_READ, 8'h00, CNT_W'(3));
		queue_cmd(CMD_PUSH, 8'h00, '0);
		queue_cmd(CMD_PUSH, 8'h00, '0);
		queue_cmd(CMD_PUSH, EPB_BYTE, '0);
		queue_cmd(CMD_PUSH, 8'h01, '0);
		queue_cmd(CMD_PUSH, 8'hff, '0);
		queue_cmd(CMD_PUSH, 8'h00, '0);
		queue_cmd(CMD_PUSH, 8'h00, '0);
		queue_cmd(CMD_PUSH, 8'h80, '0);
		queue_cmd(CMD_PUSH, 8'h55, '0);       // one past the unit length
		queue_cmd(CMD_READ, 8'h00, CNT_W'(32)); // too many bits
		queue_cmd(CMD_READ, 8'h00, CNT_W'(31));
		queue_cmd(CMD_UE, 8'h00, '0);
		queue_cmd(CMD_SE, 8'h00, '0);
		queue_cmd(CMD_READ, 8'h00, CNT_W'(0));
		queue_cmd(CMD_MORE, 8'h00, '0);
		queue_cmd(CMD_SKIP, 8'h00, '1);       // runs out of data
		// Long prefix: forty zeros then a one, then a query that finds
		// nothing past the stop bit.
		queue_cmd(CMD_BEGIN, 8'h00, CNT_W'(6));
		repeat (5) queue_cmd(CMD_PUSH, 8'h00, '0);
		queue_cmd(CMD_PUSH, 8'h80, '0);
		queue_cmd(CMD_UE, 8'h00, '0);
		queue_cmd(CMD_MORE, 8'h00, '0);
		queue_drain();

		// Random phases of mostly small units, with one full-size unit.
		for (int ph = 0; ph < 4; ph++) begin
			cur_gap = phase_gap[ph];
			while (pending_cmds.size() < 225)
				queue_unit($urandom_range(12, 1));
			if (ph == 1) begin
				queue_drain();
				queue_cmd(CMD_BEGIN, 8'h00, CNT_W'(BUFFER_DEPTH));
				repeat (40) queue_cmd(CMD_PUSH, nal_byte(), '0);
				queue_cmd(CMD_SKIP, 8'h00, CNT_W'(300));
				queue_cmd(CMD_MORE, 8'h00, '0);
				queue_cmd(CMD_SKIP, 8'h00, CNT_W'(65536));
			end
			// Wait until the driver has taken this phase before moving on,
			// so each phase keeps its own idling rate.
			while (pending_cmds.size() > 0)
				@(posedge clk);
		end

		queue_drain();
		while (pending_cmds.size() > 0 || start || n_sent != n_results)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			n_errors++;
		end
		$display("Covered %0d commands over %0d NAL units in four idling phases,",
			n_sent, n_units);
		$display("including bad lengths, prevention bytes, long prefixes and queries.");
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
design/nrbr_pkg.sv
design/nrbr_front.sv
design/nrbr_back.sv
design/nal_rbsp_bit_reader_top.sv
bench/nal_rbsp_bit_reader_top_tb.sv
